/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/hpd_pkg.sv */
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared widths, codes and types of the hysteresis peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hpd_pkg;

    localparam int SMP_W = 16;   // input sample
    localparam int THR_W = 16;   // peak threshold
    localparam int WH_W  = 15;   // window height
    localparam int ST_W  = 18;   // window and tracked levels
    localparam int IDX_W = 12;   // reported index
    localparam int LVL_W = 17;   // reported level

    localparam logic [WH_W-1:0] WINDOW_RESET = 15'd256;

    // register indexes (byte address / 4)
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WINDOW    = 1'b1;

    typedef enum logic [1:0] {
        PH_UNKNOWN = 2'd0,
        PH_PEAK    = 2'd1,
        PH_TROUGH  = 2'd2
    } phase_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] index;
        logic [LVL_W-1:0] level;
    } result_t;

endpackage

`default_nettype wire

/* rtl/hpd_cfg.sv */
// ----------------------------------------------------------------------------
// hpd_cfg
// APB register file: peak threshold and hysteresis window height.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output logic      [hpd_pkg::THR_W-1:0]        threshold,
    output logic      [hpd_pkg::WH_W-1:0]         window_height
);

    logic [hpd_pkg::THR_W-1:0] threshold_reg;
    logic [hpd_pkg::WH_W-1:0]  window_reg;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, decoded on the word address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            window_reg    <= hpd_pkg::WINDOW_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                hpd_pkg::REG_THRESHOLD: threshold_reg <= pwdata[hpd_pkg::THR_W-1:0];
                hpd_pkg::REG_WINDOW:    window_reg    <= pwdata[hpd_pkg::WH_W-1:0];
                default: ;
            endcase
        end
    end

    // read back: threshold sign-extended, window zero-extended
    always_comb
    begin
        unique case (paddr[2])
            hpd_pkg::REG_THRESHOLD:
                prdata = {{(32-hpd_pkg::THR_W){threshold_reg[hpd_pkg::THR_W-1]}},
                          threshold_reg};
            hpd_pkg::REG_WINDOW:
                prdata = {{(32-hpd_pkg::WH_W){1'b0}}, window_reg};
            default:
                prdata = '0;
        endcase
    end

    assign threshold     = threshold_reg;
    assign window_height = window_reg;

endmodule

`default_nettype wire

/* rtl/hpd_core.sv */
// ----------------------------------------------------------------------------
// hpd_core
// Detection state and the combinational window slide / phase update.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_core
#(
    parameter int MAX_FRAME = 4096
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [hpd_pkg::SMP_W-1:0]     sample,
    input  wire logic                          frame_start,
    input  wire logic [hpd_pkg::THR_W-1:0]     threshold,
    input  wire logic [hpd_pkg::WH_W-1:0]      window_height,
    output hpd_pkg::result_t                   result
);

    localparam int POS_W = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME - 1);

    logic signed [hpd_pkg::ST_W-1:0] top_reg, top_next;
    logic signed [hpd_pkg::ST_W-1:0] bot_reg, bot_next;
    logic signed [hpd_pkg::ST_W-1:0] high_reg, high_next;
    logic signed [hpd_pkg::ST_W-1:0] low_reg, low_next;
    logic        [POS_W-1:0]         hpos_reg, hpos_next;
    logic        [POS_W-1:0]         pos_reg, pos_next;
    hpd_pkg::phase_t                 phase_reg, phase_next;

    logic signed [hpd_pkg::ST_W-1:0] x;
    logic signed [hpd_pkg::ST_W-1:0] wh;
    logic signed [hpd_pkg::ST_W-1:0] thr;
    logic signed [hpd_pkg::ST_W-1:0] rep_level;
    logic        [POS_W-1:0]         rep_pos;
    logic [31:0]                     rep_pos_ext;
    logic                            hit;

    // state update for one sample
    always_comb
    begin
        x   = {{(hpd_pkg::ST_W-hpd_pkg::SMP_W){sample[hpd_pkg::SMP_W-1]}}, sample};
        wh  = {{(hpd_pkg::ST_W-hpd_pkg::WH_W){1'b0}}, window_height};
        thr = {{(hpd_pkg::ST_W-hpd_pkg::THR_W){threshold[hpd_pkg::THR_W-1]}}, threshold};

        top_next   = top_reg;
        bot_next   = bot_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        hpos_next  = hpos_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        hit        = 1'b0;
        rep_level  = high_reg;
        rep_pos    = hpos_reg;

        // frame start restarts everything at this sample
        if (frame_start)
        begin
            pos_next   = '0;
            top_next   = x;
            bot_next   = x - wh;
            high_next  = x;
            low_next   = x;
            hpos_next  = '0;
            phase_next = hpd_pkg::PH_UNKNOWN;
        end
        else if (pos_reg != POS_LAST)
        begin
            pos_next = pos_reg + 1'b1;
        end

        // slide the window
        if (x > top_next)
        begin
            top_next  = x;
            bot_next  = x - wh;
            high_next = x;
            hpos_next = pos_next;
        end
        else if (x < bot_next)
        begin
            bot_next = x;
            top_next = x + wh;
            low_next = x;
        end

        // fallen a full window below the high: report, hunt trough
        if (high_next > top_next &&
            (phase_next == hpd_pkg::PH_UNKNOWN || phase_next == hpd_pkg::PH_PEAK))
        begin
            phase_next = hpd_pkg::PH_TROUGH;
            hit        = high_next > thr;
            rep_level  = high_next;
            rep_pos    = hpos_next;
            low_next   = bot_next;
        end

        // risen a full window above the low: hunt peak
        if (low_next < bot_next && phase_next != hpd_pkg::PH_PEAK)
        begin
            phase_next = hpd_pkg::PH_PEAK;
            high_next  = top_next;
            hpos_next  = pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            bot_reg   <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
            hpos_reg  <= '0;
            pos_reg   <= '0;
            phase_reg <= hpd_pkg::PH_UNKNOWN;
        end
        else if (step)
        begin
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            hpos_reg  <= hpos_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    // index carries the low bits of the position
    assign rep_pos_ext  = 32'(rep_pos);
    assign result.hit   = hit;
    assign result.index = rep_pos_ext[hpd_pkg::IDX_W-1:0];
    assign result.level = rep_level[hpd_pkg::LVL_W-1:0];

endmodule

`default_nettype wire

/* rtl/hysteresis_peak_detector.sv */
// ----------------------------------------------------------------------------
// hysteresis_peak_detector
// Streaming peak finder with a sliding hysteresis window.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while s_tready is high (s_tuser marks a frame's
// first sample) and emits a peak item when the signal has fallen a full
// window below a high that exceeds the threshold. Sustained rate is one item
// per clock unless the master stream stalls; an item passes an input register
// and then a result register before a peak is presented on m_tdata. The
// combinational window/phase update in hpd_core between those registers
// sets this rate. Input is accepted while a result waits, as long as the
// input register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hysteresis_peak_detector
#(
    parameter int MAX_FRAME = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic        s_tuser,   // [0] frame_start
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [11:0] peak_index, [28:12] peak_level
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [hpd_pkg::THR_W-1:0] threshold;
    logic [hpd_pkg::WH_W-1:0]  window_height;

    logic                      in_valid_reg, in_valid_next;
    logic [hpd_pkg::SMP_W-1:0] sample_reg;
    logic                      start_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [hpd_pkg::IDX_W-1:0] index_reg;
    logic [hpd_pkg::LVL_W-1:0] level_reg;

    logic                      advance;
    logic                      step;
    logic                      in_acc;
    hpd_pkg::result_t          result;

    hpd_cfg u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .threshold     (threshold),
        .window_height (window_height)
    );

    hpd_core #(.MAX_FRAME(MAX_FRAME)) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .sample        (sample_reg),
        .frame_start   (start_reg),
        .threshold     (threshold),
        .window_height (window_height),
        .result        (result)
    );

    // pipeline control
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_acc   = s_tvalid && s_tready;

    always_comb
    begin
        if (in_acc)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = step && result.hit;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= s_tdata;
            start_reg  <= s_tuser;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && step && result.hit)
        begin
            index_reg <= result.index;
            level_reg <= result.level;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32-hpd_pkg::IDX_W-hpd_pkg::LVL_W){1'b0}}, level_reg, index_reg};

    // back-pressure only when both stages are full and the result is stalled
    `ASSERT_IMPLIES(a_ready_stall, clk, rst_n, !s_tready, in_valid_reg && m_tvalid && !m_tready)
    // a result only comes from an item in the input stage
    `ASSERT_NEXT(a_no_phantom, clk, rst_n, !m_tvalid && !in_valid_reg, !m_tvalid)
    // every reported level lies above the threshold
    `ASSERT_IMPLIES(a_level_thr, clk, rst_n, m_tvalid, $signed(level_reg) > $signed(threshold))

endmodule

`default_nettype wire

/* sim/tb_hysteresis_peak_detector.sv */
// ----------------------------------------------------------------------------
// tb_hysteresis_peak_detector
// Self-checking bench for the hysteresis peak detector.
// ----------------------------------------------------------------------------
// Sample items are queued by the stimulus process and fed to the slave stream
// by a clocked driver. A clocked monitor runs its own model of the sliding
// window on every accepted item and checks each peak leaving the master
// stream against the oldest predicted one. The run walks through several
// threshold and window settings, most with random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hysteresis_peak_detector;

    import hpd_pkg::*;

    localparam int MAX_FRAME    = 4096;
    localparam int DRAIN_CYCLES = 6;     // pipeline is two deep, with margin
    localparam int STALL_LIMIT  = 1000;  // cycles with no item moved
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [SMP_W-1:0] sample;
        logic             starts_frame;
    } sample_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [LVL_W-1:0] level;
    } peak_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus bookkeeping
    sample_item_t samples_to_send[$];
    sample_item_t send_item;
    peak_t        peaks_due[$];
    int           queued_n     = 0;
    int           accepted_n   = 0;
    int           mismatches   = 0;
    int           stall_cycles = 0;
    int           send_gap_pct = 0;
    int           recv_gap_pct = 0;
    logic         in_fire      = 1'b0;

    // register copies
    logic signed [THR_W-1:0] threshold_cfg = '0;
    logic        [WH_W-1:0]  height_cfg    = WINDOW_RESET;

    // window tracker state
    logic signed [ST_W-1:0]  win_top    = '0;
    logic signed [ST_W-1:0]  win_bottom = '0;
    logic signed [ST_W-1:0]  run_high   = '0;
    logic signed [ST_W-1:0]  run_low    = '0;
    logic        [IDX_W-1:0] high_at    = '0;
    logic        [IDX_W-1:0] sample_at  = '0;
    phase_t                  hunt_phase = PH_UNKNOWN;

    hysteresis_peak_detector #(
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] sample
        .s_tuser  (s_tuser),   // [0] frame_start
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [11:0] peak_index, [28:12] peak_level
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // Advance the window tracker by one sample; returns 1 when a peak is due
    function automatic bit track_sample(input logic signed [SMP_W-1:0] smp,
                                        input logic starts_frame,
                                        output peak_t pk);
        logic signed [ST_W-1:0] x;
        logic signed [ST_W-1:0] wh;
        bit                     found;
        x     = smp;
        wh    = $signed({3'b000, height_cfg});
        found = 1'b0;
        pk    = '0;

        if (starts_frame)
        begin
            sample_at  = '0;
            win_top    = x;
            win_bottom = x - wh;
            run_high   = x;
            run_low    = x;
            high_at    = '0;
            hunt_phase = PH_UNKNOWN;
        end
        else if (sample_at < MAX_FRAME - 1)
            sample_at = sample_at + 1'b1;

        // slide the window
        if (x > win_top)
        begin
            win_top    = x;
            win_bottom = x - wh;
            run_high   = x;
            high_at    = sample_at;
        end
        else if (x < win_bottom)
        begin
            win_bottom = x;
            win_top    = x + wh;
            run_low    = x;
        end

        // fallen a full window below the high: report, then look for a trough
        if (run_high > win_top && (hunt_phase == PH_UNKNOWN || hunt_phase == PH_PEAK))
        begin
            hunt_phase = PH_TROUGH;
            if (run_high > threshold_cfg)
            begin
                pk.index = high_at;
                pk.level = run_high[LVL_W-1:0];
                found    = 1'b1;
            end
            run_low = win_bottom;
        end

        // risen a full window above the low: look for a peak
        if (run_low < win_bottom && hunt_phase != PH_PEAK)
        begin
            hunt_phase = PH_PEAK;
            run_high   = win_top;
            high_at    = sample_at;
        end
        return found;
    endfunction

    // Random walk scaled to the window, with occasional jumps anywhere
    function automatic int next_level(input int lvl);
        int bound;
        int v;
        if ($urandom_range(99) < 15)
            v = int'($urandom_range(65535)) - 32768;
        else
        begin
            bound = 3 * int'(height_cfg) + 16;
            v     = lvl + int'($urandom_range(2 * bound)) - bound;
        end
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v;
    endfunction

    task automatic queue_sample(input logic [SMP_W-1:0] smp, input logic starts_frame);
        sample_item_t it;
        it.sample       = smp;
        it.starts_frame = starts_frame;
        samples_to_send.insert(samples_to_send.size(), it);
        queued_n++;
    endtask

    // Frames of random length; with carry_on the first run continues the open frame
    task automatic queue_frames(input int count, input bit carry_on);
        int lvl;
        int len;
        int k;
        int n;
        n   = 0;
        lvl = int'($urandom_range(16000)) - 8000;
        while (n < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(500, 150) : $urandom_range(80, 1);
            for (k = 0; k < len && n < count; k++)
            begin
                lvl = next_level(lvl);
                queue_sample(16'(lvl),
                             (k == 0 && !(carry_on && n == 0)) || $urandom_range(49) == 0);
                n++;
            end
        end
    endtask

    // Register write; the upper bits of the word carry random junk
    task automatic write_reg(input logic reg_sel, input logic [15:0] field);
        logic [31:0] word;
        word = $urandom;
        if (reg_sel == REG_THRESHOLD)
            word[15:0] = field;
        else
            word[14:0] = field[14:0];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_THRESHOLD)
            threshold_cfg = word[15:0];
        else
            height_cfg = word[14:0];
    endtask

    // Hold off until every item is taken and every peak has come out
    task automatic drain();
        while (accepted_n != queued_n || peaks_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // Stream driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                send_item = samples_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= send_item.sample;
                s_tuser  <= send_item.starts_frame;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Monitor: predict on accepted samples, check accepted peaks
    always @(posedge clk)
    begin : monitor
        peak_t got;
        peak_t want;
        peak_t pk;
        in_fire <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.index = m_tdata[11:0];
                got.level = m_tdata[28:12];
                if (peaks_due.size() == 0)
                    report_error($sformatf("unexpected peak index %0d level %0d",
                                           got.index, $signed(got.level)));
                else
                begin
                    want = peaks_due.pop_front();
                    if (got.index != want.index || got.level != want.level)
                        report_error($sformatf(
                            "peak index exp %0d got %0d, level exp %0d got %0d",
                            want.index, got.index, $signed(want.level),
                            $signed(got.level)));
                end
            end
            if (s_tvalid && s_tready)
            begin
                accepted_n++;
                if (track_sample(s_tdata, s_tuser, pk))
                    peaks_due.insert(peaks_due.size(), pk);
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender rarely idles, receiver often
        send_gap_pct = 6;
        recv_gap_pct = 47;

        // directed items at reset settings (threshold 0, window 256)
        queue_sample(16'sd100, 1'b0);       // before any frame: index 1
        queue_sample(-16'sd300, 1'b0);      // fall reports the pre-frame high
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h8000, 1'b0);       // full-scale fall
        queue_sample(16'h7FFF, 1'b0);       // full-scale rise
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd200, 1'b0);
        queue_sample(-16'sd50, 1'b0);       // inside the window: no peak
        queue_sample(-16'sd100, 1'b0);      // leaves the window
        queue_sample(-16'sd600, 1'b0);
        queue_sample(-16'sd400, 1'b0);
        queue_sample(-16'sd1000, 1'b1);     // peak below threshold
        queue_sample(-16'sd700, 1'b0);
        queue_sample(-16'sd2000, 1'b0);
        queue_sample(-16'sd1500, 1'b0);     // back to peak hunting
        queue_sample(16'sd16384, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(-16'sd1, 1'b1);
        queue_sample(16'sd255, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(-16'sd1, 1'b0);        // exactly on the window edge
        queue_sample(-16'sd2, 1'b0);        // one past it
        queue_sample(-16'sd300, 1'b1);
        queue_sample(16'sd0, 1'b0);
        queue_sample(-16'sd300, 1'b0);      // peak level equal to threshold
        drain();

        // lowest threshold, zero window
        write_reg(REG_THRESHOLD, 16'h8000);
        write_reg(REG_WINDOW, 16'h0000);
        queue_frames(220, 1'b0);
        drain();

        // highest threshold, widest window, settings changed mid-frame
        write_reg(REG_THRESHOLD, 16'h7FFF);
        write_reg(REG_WINDOW, 16'h7FFF);
        queue_frames(150, 1'b1);
        drain();

        // receiver rarely idles, sender often
        send_gap_pct = 47;
        recv_gap_pct = 6;
        write_reg(REG_THRESHOLD, 16'($urandom_range(65535)));
        write_reg(REG_WINDOW, 16'($urandom_range(600, 1)));
        queue_frames(250, 1'b1);
        drain();

        write_reg(REG_THRESHOLD, 16'($urandom_range(65535)));
        write_reg(REG_WINDOW, 16'($urandom_range(32767)));
        queue_frames(200, 1'b0);
        drain();

        // no idling
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_reg(REG_THRESHOLD, -16'sd100);
        write_reg(REG_WINDOW, 16'd300);
        queue_frames(60, 1'b1);
        drain();

        write_reg(REG_THRESHOLD, 16'($urandom_range(65535)));
        write_reg(REG_WINDOW, 16'($urandom_range(1000)));
        queue_frames(250, 1'b0);
        drain();

        if (mismatches == 0 && peaks_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
